FILE: rtl/core/sc2cal_pkg.sv
// Package: shared types and constants for the seconds-to-calendar converter.
`timescale 1ns / 1ps
`default_nettype none
package sc2cal_pkg;

  localparam int unsigned SECS_W      = 32;
  localparam int unsigned DAYS_W      = 16;
  localparam int unsigned STEP_W      = 1;

  localparam logic [SECS_W-1:0] EPOCH_RESET    = 32'd1262304000;
  localparam logic [SECS_W-1:0] DAY_SECONDS    = 32'd86400;
  localparam logic [SECS_W-1:0] HOUR_SECONDS   = 32'd3600;
  localparam logic [SECS_W-1:0] MINUTE_SECONDS = 32'd60;

  // Each division takes two steps: quotient, then remainder
  localparam logic [STEP_W-1:0] STEP_QUOT   = 1'b1;
  localparam logic [STEP_W-1:0] STEP_REDUCE = 1'b0;

  // Reciprocals: days = (secs>>7)*DAY_RECIP >> 35, exact below 2^25
  localparam logic [25:0] DAY_RECIP       = 26'd50903317;
  localparam int unsigned DAY_Q_LSB       = 35;
  // hours = (sod>>4)*HOUR_RECIP >> 21, exact below 2^13
  localparam logic [13:0] HOUR_RECIP      = 14'd9321;
  localparam int unsigned HOUR_Q_LSB      = 21;
  // minutes = (rest>>2)*MINUTE_RECIP >> 14, exact below 2^10
  localparam logic [10:0] MINUTE_RECIP    = 11'd1093;
  localparam int unsigned MINUTE_Q_LSB    = 14;

  localparam logic [7:0] FIRST_YEAR = 8'd10;
  localparam logic [8:0] YEAR_DAYS  = 9'd365;
  localparam logic [8:0] LEAP_DAYS  = 9'd366;
  localparam logic [3:0] MON_JAN    = 4'd0;
  localparam logic [3:0] MON_FEB    = 4'd1;
  localparam logic [3:0] MON_DEC    = 4'd11;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_t;

  typedef struct packed {
    logic              load;
    logic              div_step;
    div_sel_t          div_sel;
    logic [STEP_W-1:0] idx;
    logic              year_step;
    logic              month_step;
    logic              publish;
  } cmd_t;

  typedef struct packed {
    logic year_go;
    logic month_go;
    logic out_free;
  } sts_t;

  function automatic logic is_leap(logic [7:0] yr);
    return (yr[1:0] == 2'b00);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sc2cal_if.sv
// Interfaces: valid/ready channels for counter values and calendar results.
`timescale 1ns / 1ps
`default_nettype none
interface sc2cal_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] count;
  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

interface sc2cal_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink (input valid, input year, input month, input day,
                input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/seconds_to_calendar.sv
// Top level: converts RTC counter values to calendar date and time of day.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        count[31:0]
//   out_ch   out  valid/ready        year[7:0] month[3:0] day[4:0]
//                                    hour[4:0] minute[5:0] second[5:0]
//   cfg      in   cfg_we (no ready)  cfg_wdata[31:0] -> epoch offset
//
// One transaction at a time. From acceptance: division of days, hours and
// minutes in turn (a reciprocal multiply for the quotient, then a multiply-back
// and subtract for the remainder), the year walk over whole years past 2010
// (0..136), the month walk over month-1 (0..11), loading of the output
// register, then a return to idle before the next accept.
// Synchronous active-low reset: controller to idle, output empty, epoch
// offset to 2010-01-01. The output register frees the core, so a new
// transaction is taken while a result waits; the core only holds at its
// final step when the previous result is still unread.
`timescale 1ns / 1ps
`default_nettype none
module seconds_to_calendar (
  input  wire          clk,
  input  wire          rst_n,
  sc2cal_in_if.sink    in_ch,
  sc2cal_out_if.source out_ch,
  input  wire          cfg_we,
  input  wire  [31:0]  cfg_wdata
);
  import sc2cal_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  sc2cal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Epoch register, divider, calendar walk and output register
  sc2cal_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_count   (in_ch.count),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_year   (out_ch.year),
    .out_month  (out_ch.month),
    .out_day    (out_ch.day),
    .out_hour   (out_ch.hour),
    .out_minute (out_ch.minute),
    .out_second (out_ch.second)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

FILE: rtl/core/sc2cal_ctrl.sv
// Controller: sequences load, the three divisions, year walk, month walk and output.
`timescale 1ns / 1ps
`default_nettype none
module sc2cal_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  sc2cal_pkg::sts_t   sts,
  output sc2cal_pkg::cmd_t   cmd
);
  import sc2cal_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.div_sel    = DIV_DAY;
    cmd.idx        = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = STEP_QUOT;
          state_nxt = ST_DIV_DAY;
        end
      end
      ST_DIV_DAY: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_DAY;
        if (idx_r == STEP_REDUCE) begin
          idx_nxt   = STEP_QUOT;
          state_nxt = ST_DIV_HOUR;
        end else begin
          idx_nxt = STEP_REDUCE;
        end
      end
      ST_DIV_HOUR: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_HOUR;
        if (idx_r == STEP_REDUCE) begin
          idx_nxt   = STEP_QUOT;
          state_nxt = ST_DIV_MIN;
        end else begin
          idx_nxt = STEP_REDUCE;
        end
      end
      ST_DIV_MIN: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = DIV_MIN;
        if (idx_r == STEP_REDUCE) begin
          state_nxt = ST_YEAR;
        end else begin
          idx_nxt = STEP_REDUCE;
        end
      end
      ST_YEAR: begin
        cmd.year_step = 1'b1;
        if (!sts.year_go) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd.month_step = 1'b1;
        if (!sts.month_go) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/sc2cal_dp.sv
// Datapath: epoch register, reciprocal-multiply divider, calendar walk, output register.
`timescale 1ns / 1ps
`default_nettype none
module sc2cal_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  sc2cal_pkg::cmd_t   cmd,
  output sc2cal_pkg::sts_t   sts,
  input  wire  [31:0]        in_count,
  input  wire                cfg_we,
  input  wire  [31:0]        cfg_wdata,
  input  wire                out_ready,
  output logic               out_valid,
  output logic [7:0]         out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);
  import sc2cal_pkg::*;

  logic [SECS_W-1:0] epoch_r, epoch_nxt;
  logic [SECS_W-1:0] rem_r, rem_nxt;
  logic [DAYS_W-1:0] days_r, days_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [7:0]        year_r, year_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        oyear_r;
  logic [3:0]        omon_r;
  logic [4:0]        oday_r, ohour_r;
  logic [5:0]        omin_r, osec_r;

  logic [50:0]       day_prod;
  logic [26:0]       hour_prod;
  logic [20:0]       min_prod;
  logic [SECS_W-1:0] day_back, hour_back, min_back;
  logic [8:0]        ylen;
  logic [4:0]        mlen;

  // Quotients by reciprocal; low divisor factors of two dropped first
  assign day_prod  = rem_r[31:7] * DAY_RECIP;
  assign hour_prod = rem_r[16:4] * HOUR_RECIP;
  assign min_prod  = rem_r[11:2] * MINUTE_RECIP;

  // Quotient times divisor, taken off the remainder in the next step
  assign day_back  = {16'd0, days_r} * DAY_SECONDS;
  assign hour_back = {27'd0, hour_r} * HOUR_SECONDS;
  assign min_back  = {26'd0, min_r} * MINUTE_SECONDS;

  assign ylen   = is_leap(year_r) ? LEAP_DAYS : YEAR_DAYS;
  assign mlen   = MONTH_LEN[mon_r] +
                  {4'd0, (mon_r == MON_FEB) && is_leap(year_r)};

  assign sts.year_go  = (days_r >= {7'd0, ylen});
  assign sts.month_go = (mon_r != MON_DEC) && (days_r >= {11'd0, mlen});
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    epoch_nxt     = cfg_we ? cfg_wdata : epoch_r;
    rem_nxt       = rem_r;
    days_nxt      = days_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    year_nxt      = year_r;
    mon_nxt       = mon_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd.load) begin
      rem_nxt  = in_count - epoch_r;
      days_nxt = '0;
      hour_nxt = '0;
      min_nxt  = '0;
      year_nxt = FIRST_YEAR;
      mon_nxt  = MON_JAN;
    end
    if (cmd.div_step) begin
      if (cmd.idx == STEP_QUOT) begin
        case (cmd.div_sel)
          DIV_DAY:  days_nxt = day_prod[DAY_Q_LSB +: DAYS_W];
          DIV_HOUR: hour_nxt = hour_prod[HOUR_Q_LSB +: 5];
          DIV_MIN:  min_nxt  = min_prod[MINUTE_Q_LSB +: 6];
          default:  days_nxt = days_r;
        endcase
      end else begin
        case (cmd.div_sel)
          DIV_DAY:  rem_nxt = rem_r - day_back;
          DIV_HOUR: rem_nxt = rem_r - hour_back;
          DIV_MIN:  rem_nxt = rem_r - min_back;
          default:  rem_nxt = rem_r;
        endcase
      end
    end
    if (cmd.year_step && sts.year_go) begin
      days_nxt = days_r - {7'd0, ylen};
      year_nxt = year_r + 8'd1;
    end
    if (cmd.month_step && sts.month_go) begin
      days_nxt = days_r - {11'd0, mlen};
      mon_nxt  = mon_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= EPOCH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    days_r <= days_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    if (cmd.publish) begin
      oyear_r <= year_r;
      omon_r  <= mon_r + 4'd1;
      oday_r  <= days_r[4:0] + 5'd1;
      ohour_r <= hour_r;
      omin_r  <= min_r;
      osec_r  <= rem_r[5:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_year   = oyear_r;
  assign out_month  = omon_r;
  assign out_day    = oday_r;
  assign out_hour   = ohour_r;
  assign out_minute = omin_r;
  assign out_second = osec_r;

endmodule
`default_nettype wire

FILE: rtl/core/sc2cal_chk.sv
// Checker: port-level assertions for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sc2cal_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] year,
  input wire [3:0] month,
  input wire [4:0] day,
  input wire [4:0] hour,
  input wire [5:0] minute,
  input wire [5:0] second
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle and empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) &&
      $stable(day) && $stable(hour) && $stable(minute) && $stable(second))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while converting");

  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> year >= 8'd10 && year <= 8'd146 && month >= 4'd1 &&
      month <= 4'd12 && day >= 5'd1 && day <= 5'd31 && hour <= 5'd23 &&
      minute <= 6'd59 && second <= 6'd59)
    else $error("result field out of range");

endmodule

bind seconds_to_calendar sc2cal_chk u_sc2cal_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .year      (out_ch.year),
  .month     (out_ch.month),
  .day       (out_ch.day),
  .hour      (out_ch.hour),
  .minute    (out_ch.minute),
  .second    (out_ch.second)
);
`default_nettype wire
